FILE: hdl/dcd_pkg.sv
`timescale 1ns / 1ps

package dcd_pkg;

    localparam int SampleBits = 12;
    localparam int WindowBits = 10;
    localparam int CfgBits    = 16;
    localparam int IndexBits  = 3;

    typedef enum logic [IndexBits-1:0] {
        REG_WINDOW_MS      = 3'd0,
        REG_CLAP_THRESHOLD = 3'd1,
        REG_REFRACTORY_MS  = 3'd2,
        REG_DOUBLE_GAP_MS  = 3'd3,
        REG_SAMPLE_FLOOR   = 3'd4,
        REG_MIN_START      = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        CLAP_NONE   = 2'd0,
        CLAP_SINGLE = 2'd1,
        CLAP_DOUBLE = 2'd2
    } clap_t;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic [WindowBits-1:0] WINDOW_MS_RST      = 10'd50;
    localparam logic [SampleBits-1:0] CLAP_THRESHOLD_RST = 12'd2200;
    localparam logic [15:0]           REFRACTORY_MS_RST  = 16'd200;
    localparam logic [15:0]           DOUBLE_GAP_MS_RST  = 16'd1000;
    localparam logic [SampleBits-1:0] SAMPLE_FLOOR_RST   = 12'd1000;
    localparam logic [SampleBits-1:0] MIN_START_RST      = 12'd2040;

    typedef struct packed {
        logic                  mode;
        logic [SampleBits-1:0] sample_value;
    } item_t;

    typedef struct packed {
        logic [1:0]            clap_result;
        logic [SampleBits-1:0] peak_level;
    } result_t;

endpackage

FILE: hdl/double_clap_detector_core.sv
`timescale 1ns / 1ps

// Double clap detector core.
// Item channel (item_valid/item_ready/item): each beat is either a microphone
// sample (mode 0) or a one-millisecond tick (mode 1). Samples only update the
// window extremes and never produce a result beat. A tick that closes the
// window produces exactly one result beat: no clap, single or double clap,
// plus the peak-to-peak level of the closed window.
// The result of a closing tick is registered in the output register, or in
// the skid register while a stalled beat waits there. Throughput: one item per
// cycle while item_ready is high; the state registers do all updates.
// Stall: a two-entry output (output register plus skid register) keeps
// item_ready high while one result waits; item_ready drops only when both
// entries are full, and rises again as soon as result_ready drains one.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// write only while idle. Unknown indexes are ignored.
// Reset: rst_n clears the window, sets the time since the last clap to
// saturated, clears the clap count, loads register defaults and empties the
// output. No clearing pass is needed.
module double_clap_detector_core #(
    parameter int TIME_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  dcd_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output dcd_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [dcd_pkg::IndexBits-1:0]       cfg_index,
    input  logic [dcd_pkg::CfgBits-1:0]         cfg_data
);

    localparam int SB = dcd_pkg::SampleBits;
    localparam int WB = dcd_pkg::WindowBits;
    localparam int CmpBits = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

    logic [WB-1:0]        window_ms_reg;
    logic [SB-1:0]        clap_threshold_reg;
    logic [15:0]          refractory_ms_reg;
    logic [15:0]          double_gap_ms_reg;
    logic [SB-1:0]        sample_floor_reg;
    logic [SB-1:0]        min_start_reg;

    logic [SB-1:0]        window_max_reg, window_max_next;
    logic [SB-1:0]        window_min_reg, window_min_next;
    logic [WB-1:0]        window_elapsed_reg, window_elapsed_next;
    logic [TIME_BITS-1:0] since_reg, since_next;
    logic [1:0]           clap_count_reg, clap_count_next;

    logic                 out_valid_reg;
    dcd_pkg::result_t     out_reg;
    logic                 skid_valid_reg;
    dcd_pkg::result_t     skid_reg;

    logic                 accept;
    logic                 closes;
    dcd_pkg::result_t     res;

    logic [TIME_BITS-1:0] since_inc;
    logic [WB-1:0]        elapsed_inc;
    logic [WB-1:0]        limit;
    logic [SB-1:0]        peak;
    logic [CmpBits-1:0]   since_cmp;
    logic [CmpBits-1:0]   refr_cmp;
    logic [CmpBits-1:0]   gap_cmp;
    logic [1:0]           count_inc;
    logic [SB:0]          min_sum;
    logic                 is_clap;

    assign item_ready   = !skid_valid_reg;
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        since_inc   = (since_reg == TimeMax) ? since_reg : since_reg + 1'b1;
        elapsed_inc = window_elapsed_reg + 1'b1;
        limit       = (window_ms_reg == '0) ? {{(WB-1){1'b0}}, 1'b1} : window_ms_reg;
        peak        = (window_max_reg > window_min_reg) ? window_max_reg - window_min_reg : '0;
        since_cmp   = CmpBits'(since_inc);
        refr_cmp    = CmpBits'(refractory_ms_reg);
        gap_cmp     = CmpBits'(double_gap_ms_reg);
        count_inc   = clap_count_reg + 1'b1;
        min_sum     = {1'b0, window_min_reg} + {1'b0, item.sample_value};
        is_clap     = (peak > clap_threshold_reg) && (since_cmp > refr_cmp);

        window_max_next     = window_max_reg;
        window_min_next     = window_min_reg;
        window_elapsed_next = window_elapsed_reg;
        since_next          = since_reg;
        clap_count_next     = clap_count_reg;
        closes              = 1'b0;
        res.clap_result     = dcd_pkg::CLAP_NONE;
        res.peak_level      = peak;

        if (item.mode == dcd_pkg::MODE_SAMPLE)
        begin
            if (item.sample_value >= sample_floor_reg)
            begin
                if (item.sample_value > window_max_reg)
                    window_max_next = item.sample_value;
                else if (item.sample_value < window_min_reg)
                    window_min_next = min_sum[SB:1];
            end
        end
        else
        begin
            since_next          = since_inc;
            window_elapsed_next = elapsed_inc;
            if (elapsed_inc >= limit)
            begin
                closes = 1'b1;
                if (is_clap)
                begin
                    if ((since_cmp < gap_cmp) && (count_inc == 2'd2))
                    begin
                        res.clap_result = dcd_pkg::CLAP_DOUBLE;
                        clap_count_next = 2'd0;
                    end
                    else
                    begin
                        res.clap_result = dcd_pkg::CLAP_SINGLE;
                        clap_count_next = 2'd1;
                    end
                    since_next = '0;
                end
                else if ((since_cmp > gap_cmp) && (clap_count_reg == 2'd1))
                begin
                    clap_count_next = 2'd0;
                end
                window_max_next     = '0;
                window_min_next     = min_start_reg;
                window_elapsed_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg      <= dcd_pkg::WINDOW_MS_RST;
            clap_threshold_reg <= dcd_pkg::CLAP_THRESHOLD_RST;
            refractory_ms_reg  <= dcd_pkg::REFRACTORY_MS_RST;
            double_gap_ms_reg  <= dcd_pkg::DOUBLE_GAP_MS_RST;
            sample_floor_reg   <= dcd_pkg::SAMPLE_FLOOR_RST;
            min_start_reg      <= dcd_pkg::MIN_START_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcd_pkg::REG_WINDOW_MS:      window_ms_reg      <= cfg_data[WB-1:0];
                dcd_pkg::REG_CLAP_THRESHOLD: clap_threshold_reg <= cfg_data[SB-1:0];
                dcd_pkg::REG_REFRACTORY_MS:  refractory_ms_reg  <= cfg_data;
                dcd_pkg::REG_DOUBLE_GAP_MS:  double_gap_ms_reg  <= cfg_data;
                dcd_pkg::REG_SAMPLE_FLOOR:   sample_floor_reg   <= cfg_data[SB-1:0];
                dcd_pkg::REG_MIN_START:      min_start_reg      <= cfg_data[SB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_max_reg     <= '0;
            window_min_reg     <= dcd_pkg::MIN_START_RST;
            window_elapsed_reg <= '0;
            since_reg          <= TimeMax;
            clap_count_reg     <= 2'd0;
        end
        else if (accept)
        begin
            window_max_reg     <= window_max_next;
            window_min_reg     <= window_min_next;
            window_elapsed_reg <= window_elapsed_next;
            since_reg          <= since_next;
            clap_count_reg     <= clap_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !result_ready)
        begin
            if (accept && closes)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= accept && closes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !result_ready)
        begin
            if (accept && closes)
                skid_reg <= res;
        end
        else if (skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (accept && closes)
        begin
            out_reg <= res;
        end
    end

endmodule

FILE: hdl/dcd_checker.sv
`timescale 1ns / 1ps

module dcd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input dcd_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_ready,
    input dcd_pkg::result_t result
);

    // hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // a fresh result beat only follows an accepted tick
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready
                                      && (item.mode == dcd_pkg::MODE_TICK)))
        else $error("result beat without an accepted tick");

    // zero level never reports a clap
    a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.peak_level == '0)
            |-> result.clap_result == dcd_pkg::CLAP_NONE)
        else $error("clap reported with zero level");

    // drop item_ready only behind a pending result
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("item_ready low with empty output");

endmodule

bind double_clap_detector_core dcd_checker u_dcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

FILE: tb/sv/tb_double_clap_detector_core.sv
`timescale 1ns / 1ps

module tb_double_clap_detector_core;

    localparam int SB = dcd_pkg::SampleBits;
    localparam int WB = dcd_pkg::WindowBits;

    typedef struct packed {
        logic [WB-1:0] window_ms;
        logic [SB-1:0] clap_threshold;
        logic [15:0]   refractory_ms;
        logic [15:0]   double_gap_ms;
        logic [SB-1:0] sample_floor;
        logic [SB-1:0] min_start;
    } clap_cfg_t;

    typedef struct {
        bit               is_cfg;
        clap_cfg_t        cfg;
        dcd_pkg::item_t   beat;
        bit               typed;
        dcd_pkg::result_t want;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          item_valid = 1'b0;
    logic                          item_ready;
    dcd_pkg::item_t                item_beat = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    dcd_pkg::result_t              result_beat;
    logic                          cfg_we = 1'b0;
    logic [dcd_pkg::IndexBits-1:0] cfg_index = '0;
    logic [dcd_pkg::CfgBits-1:0]   cfg_data = '0;

    clap_cfg_t     det_cfg;
    logic [SB-1:0] win_max;
    logic [SB-1:0] win_min;
    logic [WB-1:0] win_elapsed;
    logic [15:0]   since_clap;
    logic [1:0]    clap_cnt;

    dcd_pkg::result_t pending_windows[$];
    plan_row_t        plan[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int beats_sent = 0;
    int windows_predicted = 0;
    int windows_checked = 0;
    int singles_seen = 0;
    int doubles_seen = 0;
    int settings = 0;
    int idle_send[4] = '{0, 49, 0, 28};
    int idle_recv[4] = '{0, 0, 49, 28};

    double_clap_detector_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_beat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void reset_detector();
        det_cfg = '{dcd_pkg::WINDOW_MS_RST, dcd_pkg::CLAP_THRESHOLD_RST,
                    dcd_pkg::REFRACTORY_MS_RST, dcd_pkg::DOUBLE_GAP_MS_RST,
                    dcd_pkg::SAMPLE_FLOOR_RST, dcd_pkg::MIN_START_RST};
        win_max = '0;
        win_min = dcd_pkg::MIN_START_RST;
        win_elapsed = '0;
        since_clap = '1;
        clap_cnt = '0;
    endfunction

    function automatic bit advance_detector(input dcd_pkg::item_t beat,
                                            output dcd_pkg::result_t res);
        logic [SB-1:0] s;
        logic [SB:0]   sum;
        logic [WB-1:0] limit;
        logic [SB-1:0] peak;
        res = '0;
        if (beat.mode == dcd_pkg::MODE_SAMPLE)
        begin
            s = beat.sample_value;
            if (s >= det_cfg.sample_floor)
            begin
                if (s > win_max)
                begin
                    win_max = s;
                end
                else if (s < win_min)
                begin
                    sum = {1'b0, win_min} + {1'b0, s};
                    win_min = sum[SB:1];
                end
            end
            return 1'b0;
        end
        if (since_clap != '1)
        begin
            since_clap++;
        end
        win_elapsed++;
        limit = (det_cfg.window_ms == '0) ? WB'(1) : det_cfg.window_ms;
        if (win_elapsed < limit)
        begin
            return 1'b0;
        end
        peak = (win_max > win_min) ? win_max - win_min : '0;
        res.peak_level = peak;
        res.clap_result = dcd_pkg::CLAP_NONE;
        if (peak > det_cfg.clap_threshold && since_clap > det_cfg.refractory_ms)
        begin
            clap_cnt++;
            if (since_clap < det_cfg.double_gap_ms && clap_cnt == 2'd2)
            begin
                res.clap_result = dcd_pkg::CLAP_DOUBLE;
                clap_cnt = '0;
            end
            else
            begin
                res.clap_result = dcd_pkg::CLAP_SINGLE;
                clap_cnt = 2'd1;
            end
            since_clap = '0;
        end
        else if (since_clap > det_cfg.double_gap_ms && clap_cnt == 2'd1)
        begin
            clap_cnt = '0;
        end
        win_max = '0;
        win_min = det_cfg.min_start;
        win_elapsed = '0;
        return 1'b1;
    endfunction

    function automatic int pick(input int ext_lo, input int ext_hi, input int lo, input int hi);
        int r;
        r = $urandom_range(7);
        if (r == 0)
        begin
            return ext_lo;
        end
        if (r == 1)
        begin
            return ext_hi;
        end
        return $urandom_range(hi, lo);
    endfunction

    function automatic clap_cfg_t random_config();
        clap_cfg_t c;
        c.window_ms      = WB'(pick(0, 6, 1, 4));
        c.clap_threshold = SB'(pick(0, 4095, 200, 2500));
        c.refractory_ms  = 16'(pick(0, 65535, 0, 6));
        c.double_gap_ms  = 16'(pick(0, 65535, 0, 30));
        c.sample_floor   = SB'(pick(0, 4095, 0, 1500));
        c.min_start      = SB'(pick(0, 4095, 0, 4095));
        return c;
    endfunction

    function automatic dcd_pkg::item_t random_beat(input int tick_pct);
        dcd_pkg::item_t b;
        b.mode = ($urandom_range(99) < tick_pct) ? dcd_pkg::MODE_TICK : dcd_pkg::MODE_SAMPLE;
        case ($urandom_range(3))
            1: b.sample_value = SB'($urandom_range(4095, 2800));
            2: b.sample_value = SB'($urandom_range(1200, 0));
            default: b.sample_value = SB'($urandom);
        endcase
        return b;
    endfunction

    function automatic void add_beat(input logic mode, input int value, input bit typed,
                                     input dcd_pkg::clap_t want_clap, input int want_peak);
        plan_row_t r;
        r = '{default: '0};
        r.beat.mode = mode;
        r.beat.sample_value = SB'(value);
        r.typed = typed;
        r.want.clap_result = want_clap;
        r.want.peak_level = SB'(want_peak);
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(input clap_cfg_t c);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg = c;
        plan.push_back(r);
    endfunction

    task automatic send_beat(input dcd_pkg::item_t beat, input bit typed,
                             input dcd_pkg::result_t want);
        dcd_pkg::result_t res;
        item_valid <= 1'b1;
        item_beat <= beat;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
        if (advance_detector(beat, res))
        begin
            pending_windows.push_back(typed ? want : res);
            windows_predicted++;
        end
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (pending_windows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input clap_cfg_t c);
        dcd_pkg::reg_index_t slot [6];
        logic [15:0]         word [6];
        slot = '{dcd_pkg::REG_WINDOW_MS, dcd_pkg::REG_CLAP_THRESHOLD,
                 dcd_pkg::REG_REFRACTORY_MS, dcd_pkg::REG_DOUBLE_GAP_MS,
                 dcd_pkg::REG_SAMPLE_FLOOR, dcd_pkg::REG_MIN_START};
        word[0] = {6'($urandom), c.window_ms};
        word[1] = {4'($urandom), c.clap_threshold};
        word[2] = c.refractory_ms;
        word[3] = c.double_gap_ms;
        word[4] = {4'($urandom), c.sample_floor};
        word[5] = {4'($urandom), c.min_start};
        for (int k = 0; k < 6; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= slot[k];
            cfg_data <= word[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        det_cfg = c;
        settings++;
    endtask

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : check_windows
        dcd_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            windows_checked++;
            if (result_beat.clap_result == dcd_pkg::CLAP_SINGLE)
            begin
                singles_seen++;
            end
            if (result_beat.clap_result == dcd_pkg::CLAP_DOUBLE)
            begin
                doubles_seen++;
            end
            if (pending_windows.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result beat at %0t: clap %0d peak %0d",
                             $time, result_beat.clap_result, result_beat.peak_level);
                end
            end
            else
            begin
                want = pending_windows.pop_front();
                if (result_beat.clap_result !== want.clap_result ||
                    result_beat.peak_level !== want.peak_level)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch at %0t: clap exp %0d got %0d, peak exp %0d got %0d",
                                 $time, want.clap_result, result_beat.clap_result,
                                 want.peak_level, result_beat.peak_level);
                    end
                end
            end
        end
    end

    initial
    begin
        int target;
        reset_detector();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        add_beat(dcd_pkg::MODE_SAMPLE, 4095, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 0, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 1500, 0, dcd_pkg::CLAP_NONE, 0);
        add_cfg('{10'd0, 12'd2200, 16'd200, 16'd1000, 12'd1000, 12'd2040});
        add_beat(dcd_pkg::MODE_TICK, 4095, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_TICK, 0, 1, dcd_pkg::CLAP_NONE, 0);
        add_cfg('{10'd1, 12'd0, 16'd0, 16'hFFFF, 12'd0, 12'd4095});
        add_beat(dcd_pkg::MODE_SAMPLE, 0, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 4095, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_TICK, 2730, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 100, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_TICK, 1365, 1, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 4095, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_TICK, 4095, 1, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 4000, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 2000, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_TICK, 0, 0, dcd_pkg::CLAP_NONE, 0);
        add_cfg('{10'd2, 12'd4095, 16'hFFFF, 16'd0, 12'd4095, 12'd0});
        add_beat(dcd_pkg::MODE_TICK, 0, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_TICK, 0, 1, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 4094, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_SAMPLE, 4095, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_TICK, 0, 0, dcd_pkg::CLAP_NONE, 0);
        add_beat(dcd_pkg::MODE_TICK, 0, 1, dcd_pkg::CLAP_NONE, 4095);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_config(plan[i].cfg);
            end
            else
            begin
                send_beat(plan[i].beat, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < 8; p++)
        begin
            settle();
            write_config(random_config());
            send_idle_pct = idle_send[p % 4];
            stall_pct = idle_recv[p % 4];
            for (int n = 0; n < 50; n++)
            begin
                if (p == 1 && n == 25)
                begin
                    item_valid <= 1'b0;
                    do
                    begin
                        @(posedge clk);
                    end
                    while (pending_windows.size() != 0);
                end
                send_beat(random_beat(30), 1'b0, '0);
            end
        end

        // hold a long window until two windows have closed
        settle();
        send_idle_pct = 0;
        stall_pct = 0;
        write_config('{10'd16, 12'd0, 16'd0, 16'hFFFF, 12'd0, 12'd0});
        target = windows_predicted + 2;
        while (windows_predicted < target)
        begin
            send_beat(random_beat(90), 1'b0, '0);
        end

        settle();
        $display("sent %0d beats over %0d register settings, checked %0d closed windows",
                 beats_sent, settings, windows_checked);
        $display("claps reported: %0d single, %0d double", singles_seen, doubles_seen);
        if (errors == 0 && pending_windows.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
